/* src/ascf_pkg.sv */
`default_nettype none

package ascf_pkg;

	// Defaults for the top-level parameters.
	localparam int MaxDims    = 64;
	localparam int ValueWidth = 16;

	// CORDIC row: one cell per iteration, Q30 datapath.
	localparam int CordicSteps = 16;
	localparam int XyWidth     = 34;
	localparam int ZWidth      = 33;
	localparam int IndexMax    = 127;

	localparam logic signed [XyWidth-1:0] CordicX0   = 34'sd652032874;
	localparam logic signed [31:0]        RadToPhase = 32'sd683565276;

	// Register indexes on the configuration port.
	localparam logic [1:0] RegAngleMask = 2'd0;
	localparam logic [1:0] RegScaleMode = 2'd1;
	localparam logic [1:0] RegDimCount  = 2'd2;

	// Scale modes; any other code is taken as radians.
	localparam logic [1:0] ScaleTurns     = 2'd1;
	localparam logic [1:0] ScaleHalfTurns = 2'd2;

	typedef enum logic [1:0] {
		StIdle,
		StCalc,
		StSendFirst,
		StSendLast
	} ascf_state_t;

	// Data handed from one CORDIC cell to the next.
	typedef struct packed {
		logic                      valid;
		logic [1:0]                quad;
		logic signed [XyWidth-1:0] x;
		logic signed [XyWidth-1:0] y;
		logic signed [ZWidth-1:0]  z;
	} ascf_cordic_t;

	// Rotation angle of each iteration, with a full turn as 2^32.
	function automatic logic signed [ZWidth-1:0] atan_turns(input int step);
		logic signed [ZWidth-1:0] a;
		case (step)
			0:       a = 33'sd536870912;
			1:       a = 33'sd316933406;
			2:       a = 33'sd167458907;
			3:       a = 33'sd85004756;
			4:       a = 33'sd42667331;
			5:       a = 33'sd21354465;
			6:       a = 33'sd10679838;
			7:       a = 33'sd5340245;
			8:       a = 33'sd2670163;
			9:       a = 33'sd1335087;
			10:      a = 33'sd667544;
			11:      a = 33'sd333772;
			12:      a = 33'sd166886;
			13:      a = 33'sd83443;
			14:      a = 33'sd41722;
			15:      a = 33'sd20861;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Round a Q30 value to Q4.12, halves toward plus infinity.
	function automatic logic signed [31:0] round_q12(input logic signed [XyWidth-1:0] v);
		logic signed [XyWidth-1:0] t;
		t = v + 34'sd131072;
		return 32'(t >>> 18);
	endfunction

endpackage

`default_nettype wire

/* src/angle_to_sine_cosine_features.sv */
`default_nettype none

// Angle to sine/cosine feature encoder. State vectors arrive one element per
// input item on the s_ stream, with s_tlast on the final element. An element
// whose position bit is set in angle_mask is scaled to an angle (radians,
// unit turns or half turns, per scale_mode) and produces two result items,
// its sine and then its cosine in signed Q4.12; every other element is
// passed through unchanged as one result item. When s_tlast arrives at a
// position count other than dim_count, the element is dropped and a single
// result item with feature 0, tlast 1 and tuser (length error) 1 is sent,
// and the count restarts. The block handles one element at a time: a pass
// through or length error element is handed out, and an angle element
// passes through the phase mapping multiplier and the row of sixteen CORDIC
// cells and then hands out its sine and cosine items, before the next
// element is accepted. Configuration registers sit on an APB port at byte
// addresses 0 (angle_mask), 8 (scale_mode) and 16 (dim_count); write them
// only while the block is idle.
module angle_to_sine_cosine_features
	import ascf_pkg::*;
#(
	parameter int MAX_DIMS    = MaxDims,
	parameter int VALUE_WIDTH = ValueWidth,
	localparam int DataWidth  = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input stream.
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [DataWidth-1:0] s_tdata,   // [VALUE_WIDTH-1:0] sample
	input  wire logic                 s_tlast,   // last_element
	// Result stream.
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [DataWidth-1:0]      m_tdata,   // [VALUE_WIDTH-1:0] feature
	output logic                      m_tlast,   // last_feature
	output logic [0:0]                m_tuser,   // [0] length_error
	// Configuration port.
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [4:0]           paddr,
	input  wire logic [63:0]          pwdata,
	output logic [63:0]               prdata,
	output logic                      pready
);

	// Configuration registers.
	logic [63:0] angle_mask_q;
	logic [1:0]  scale_mode_q;
	logic [6:0]  dim_count_q;
	logic [1:0]  reg_index;
	logic        cfg_write;

	// Control.
	ascf_state_t state_q;
	ascf_state_t state_d;
	logic [6:0]  element_index_q;
	logic        in_fire;
	logic        out_fire;
	logic        in_range;
	logic        is_angle;
	logic        len_bad;
	logic        drop;
	logic        start;

	// Result holding registers.
	logic [VALUE_WIDTH-1:0] sin_q;
	logic [VALUE_WIDTH-1:0] res_q;
	logic                   last_q;
	logic                   err_q;

	// CORDIC row.
	ascf_cordic_t               chain [CordicSteps+1];
	logic signed [XyWidth-1:0]  x_fin;
	logic signed [XyWidth-1:0]  y_fin;
	logic signed [XyWidth-1:0]  sin_raw;
	logic signed [XyWidth-1:0]  cos_raw;
	logic signed [31:0]         sin_rnd;
	logic signed [31:0]         cos_rnd;

	// ---------------------------------------------------------------------
	// APB registers. The access is always ready; paddr[4:3] picks the register.
	// ---------------------------------------------------------------------
	assign pready    = 1'b1;
	assign reg_index = paddr[4:3];
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_mask_q <= '0;
			scale_mode_q <= '0;
			dim_count_q  <= 7'd1;
		end else if (cfg_write) begin
			unique case (reg_index)
				RegAngleMask: angle_mask_q <= pwdata;
				RegScaleMode: scale_mode_q <= pwdata[1:0];
				RegDimCount:  dim_count_q  <= pwdata[6:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			RegAngleMask: prdata = angle_mask_q;
			RegScaleMode: prdata = 64'(scale_mode_q);
			RegDimCount:  prdata = 64'(dim_count_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Element classification at the input handshake.
	// ---------------------------------------------------------------------
	assign s_tready = (state_q == StIdle);
	assign in_fire  = s_tvalid & s_tready;
	assign out_fire = m_tvalid & m_tready;
	assign in_range = element_index_q < 7'(MAX_DIMS);
	assign is_angle = in_range & angle_mask_q[element_index_q[5:0]];
	// The final element must land exactly on dim_count.
	assign len_bad  = ({1'b0, element_index_q} + 8'd1) != {1'b0, dim_count_q};
	assign drop     = s_tlast & len_bad;
	assign start    = in_fire & is_angle & ~drop;

	// Position counter: restarts on the last element, saturates otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_index_q <= '0;
		end else if (in_fire) begin
			if (s_tlast) begin
				element_index_q <= '0;
			end else if (element_index_q < 7'(IndexMax)) begin
				element_index_q <= element_index_q + 7'd1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Phase mapping and the row of CORDIC cells.
	// ---------------------------------------------------------------------
	ascf_phase_map #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_phase_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    (s_tdata[VALUE_WIDTH-1:0]),
		.scale_mode(scale_mode_q),
		.seed      (chain[0])
	);

	for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
		ascf_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (chain[i]),
			.dout  (chain[i+1])
		);
	end

	// Undo the quadrant split and round both results to Q4.12.
	assign x_fin = $signed(chain[CordicSteps].x);
	assign y_fin = $signed(chain[CordicSteps].y);

	always_comb begin
		case (chain[CordicSteps].quad)
			2'd0: begin
				sin_raw = y_fin;
				cos_raw = x_fin;
			end
			2'd1: begin
				sin_raw = x_fin;
				cos_raw = -y_fin;
			end
			2'd2: begin
				sin_raw = -y_fin;
				cos_raw = -x_fin;
			end
			default: begin
				sin_raw = -x_fin;
				cos_raw = y_fin;
			end
		endcase
	end

	assign sin_rnd = round_q12(sin_raw);
	assign cos_rnd = round_q12(cos_raw);

	// ---------------------------------------------------------------------
	// Sequencer: accept, compute if needed, then hand out one or two items.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		m_tvalid = 1'b0;
		m_tdata  = DataWidth'(res_q);
		m_tlast  = last_q;
		m_tuser  = err_q;
		unique case (state_q)
			StIdle: begin
				if (in_fire) begin
					state_d = start ? StCalc : StSendLast;
				end
			end
			StCalc: begin
				if (chain[CordicSteps].valid) begin
					state_d = StSendFirst;
				end
			end
			StSendFirst: begin
				// The sine is never the final item of a vector.
				m_tvalid = 1'b1;
				m_tdata  = DataWidth'(sin_q);
				m_tlast  = 1'b0;
				m_tuser  = 1'b0;
				if (out_fire) begin
					state_d = StSendLast;
				end
			end
			StSendLast: begin
				m_tvalid = 1'b1;
				if (out_fire) begin
					state_d = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_q <= s_tlast;
			err_q  <= drop;
			if (drop) begin
				res_q <= '0;
			end else begin
				res_q <= s_tdata[VALUE_WIDTH-1:0];
			end
		end else if (state_q == StCalc && chain[CordicSteps].valid) begin
			sin_q <= sin_rnd[VALUE_WIDTH-1:0];
			res_q <= cos_rnd[VALUE_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

/* src/ascf_phase_map.sv */
`default_nettype none

// Maps a sample to a phase (full turn = 2^32), splits off the nearest
// quadrant and seeds the first CORDIC cell. Two register stages.
module ascf_phase_map
	import ascf_pkg::*;
#(
	parameter int VALUE_WIDTH = ValueWidth
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] sample,
	input  wire logic [1:0]             scale_mode,
	output ascf_cordic_t                seed
);

	logic signed [31:0] s32_d;
	logic signed [63:0] prod_d;

	logic               valid_s1;
	logic signed [31:0] s32_s1;
	logic signed [63:0] prod_s1;
	logic [1:0]         mode_s1;

	logic [31:0] phase;
	logic [31:0] qsum;
	logic [1:0]  quad;
	logic [31:0] rest;

	assign s32_d  = 32'($signed(sample));
	assign prod_d = 64'(s32_d) * 64'(RadToPhase);

	always_ff @(posedge clk) begin
		s32_s1  <= s32_d;
		prod_s1 <= prod_d;
		mode_s1 <= scale_mode;
	end

	always_comb begin
		case (mode_s1)
			ScaleTurns:     phase = 32'(s32_s1 <<< 20);
			ScaleHalfTurns: phase = 32'(s32_s1 <<< 19);
			default:        phase = 32'((prod_s1 + 64'sd2048) >>> 12);
		endcase
		qsum = phase + 32'h2000_0000;
		quad = qsum[31:30];
		rest = phase - {quad, 30'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			seed     <= '0;
		end else begin
			valid_s1   <= start;
			seed.valid <= valid_s1;
			seed.quad  <= quad;
			seed.x     <= CordicX0;
			seed.y     <= '0;
			seed.z     <= ZWidth'($signed(rest));
		end
	end

endmodule

`default_nettype wire

/* src/ascf_cordic_cell.sv */
`default_nettype none

// One CORDIC iteration: rotates toward zero residual angle and hands the
// result to the next cell.
module ascf_cordic_cell
	import ascf_pkg::*;
#(
	parameter int STEP = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ascf_cordic_t  din,
	output ascf_cordic_t       dout
);

	logic signed [XyWidth-1:0] x;
	logic signed [XyWidth-1:0] y;
	logic signed [ZWidth-1:0]  z;
	logic signed [XyWidth-1:0] xs;
	logic signed [XyWidth-1:0] ys;
	logic signed [ZWidth-1:0]  a;

	assign x  = $signed(din.x);
	assign y  = $signed(din.y);
	assign z  = $signed(din.z);
	assign xs = x >>> STEP;
	assign ys = y >>> STEP;
	assign a  = atan_turns(STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.quad  <= din.quad;
			if (!z[ZWidth-1]) begin
				dout.x <= x - ys;
				dout.y <= y + xs;
				dout.z <= z - a;
			end else begin
				dout.x <= x + ys;
				dout.y <= y - xs;
				dout.z <= z + a;
			end
		end
	end

endmodule

`default_nettype wire
